>>> rtl/core/kvd_pkg.sv
// Shared types, codes and helper functions for the key/value list decoder.
// No dependencies; every other file in rtl/core imports this package.
package kvd_pkg;

  // Default depth of the held whitespace run
  localparam int WS_RUN_MAX_DEF = 32;
  // Default depth of the command queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;

  // Configuration register indexes
  localparam logic CFG_PART_SEPARATOR = 1'b0;
  localparam logic CFG_TRIM_MODE      = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] PART_SEPARATOR_RST = 8'h26;
  localparam logic       TRIM_MODE_RST      = 1'b0;

  // Result kinds
  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Pending escape states
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_ONE  = 2'd1;
  localparam logic [1:0] ESC_TWO  = 2'd2;

  // Character codes
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Part phase, one-hot
  typedef enum logic [2:0] {
    PH_KEY   = 3'b001,
    PH_VALUE = 3'b010,
    PH_SKIP  = 3'b100
  } phase_t;

  // One command from front to back: the results of one item, in this order:
  // pre escape text, held whitespace (carried beside the struct), data byte,
  // post escape text, end marker.
  typedef struct packed {
    logic       val_kind;   // 1 value bytes, 0 key bytes
    logic       pre_pct;
    logic       pre_chr;
    logic [7:0] pre_char;
    logic       data_en;
    logic [7:0] data_byte;
    logic       post_pct;
    logic       post_chr;
    logic [7:0] post_char;
    logic       marker;
    logic       ovf;
  } cmd_t;

  // Hex digit value: bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/kvd_front.sv
// Front end: accepts text bytes, tracks part, escape and whitespace state,
// and turns each item that gives results into one command for the back end. Uses kvd_pkg.
module kvd_front #(
  parameter int WS_RUN_MAX = kvd_pkg::WS_RUN_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_byte,
  input  logic                               in_eot,
  input  logic [7:0]                         part_separator,
  input  logic                               trim_mode,
  input  logic                               q_full,
  output logic                               push,
  output kvd_pkg::cmd_t                      cmd,
  output logic [$clog2(WS_RUN_MAX+1)-1:0]    cmd_ws_cnt,
  output logic [WS_RUN_MAX-1:0]              cmd_ws_kinds
);
  import kvd_pkg::*;

  localparam int CNT_W = $clog2(WS_RUN_MAX + 2);
  localparam int RUN_W = $clog2(WS_RUN_MAX + 1);

  phase_t                phase, phase_next;
  logic                  key_nonempty, key_nonempty_next;
  logic                  leading_ws, leading_ws_next;
  logic [1:0]            esc_cnt, esc_cnt_next;
  logic [7:0]            esc_chr, esc_chr_next;
  logic [CNT_W-1:0]      run_cnt, run_cnt_next;
  logic [WS_RUN_MAX-1:0] run_kinds, run_kinds_next;

  logic [1:0] esc_eff;
  logic       run_over;
  logic       is_ws;
  logic       is_tab;
  logic       plain;
  logic       accept;
  logic       nonempty;
  logic [4:0] hv_b;
  logic [4:0] hv_c;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Decode one item
  always_comb begin
    phase_next        = phase;
    key_nonempty_next = key_nonempty;
    leading_ws_next   = leading_ws;
    esc_cnt_next      = esc_cnt;
    esc_chr_next      = esc_chr;
    run_cnt_next      = run_cnt;
    run_kinds_next    = run_kinds;
    cmd               = '0;
    cmd.val_kind      = (phase == PH_VALUE);
    cmd_ws_cnt        = '0;
    cmd_ws_kinds      = '0;
    esc_eff           = esc_cnt;
    plain             = 1'b0;
    run_over          = run_cnt > CNT_W'(WS_RUN_MAX);
    is_tab            = (in_byte == CH_TAB);
    is_ws             = (in_byte == CH_SPACE) || is_tab;
    hv_b              = hex_val(in_byte);
    hv_c              = hex_val(esc_chr);

    if (in_byte == part_separator) begin
      // close the part
      cmd.ovf = run_over;
      if ((phase == PH_KEY || phase == PH_VALUE) && key_nonempty) begin
        cmd.pre_pct  = (esc_cnt != ESC_NONE);
        cmd.pre_chr  = (esc_cnt == ESC_TWO);
        cmd.pre_char = esc_chr;
        cmd.marker   = 1'b1;
      end
      phase_next        = PH_KEY;
      key_nonempty_next = 1'b0;
      leading_ws_next   = 1'b1;
      esc_cnt_next      = ESC_NONE;
      esc_chr_next      = 8'h00;
      run_cnt_next      = '0;
      run_kinds_next    = '0;
    end else if (phase != PH_KEY && phase != PH_VALUE) begin
      // skip the rest of a part with an empty key
    end else if (phase == PH_KEY && in_byte == CH_EQUAL) begin
      // end of key: drop trailing whitespace
      cmd.ovf        = run_over;
      run_cnt_next   = '0;
      run_kinds_next = '0;
      if (key_nonempty) begin
        cmd.pre_pct     = (esc_cnt != ESC_NONE);
        cmd.pre_chr     = (esc_cnt == ESC_TWO);
        cmd.pre_char    = esc_chr;
        esc_cnt_next    = ESC_NONE;
        phase_next      = PH_VALUE;
        leading_ws_next = 1'b1;
      end else begin
        phase_next = PH_SKIP;
      end
    end else if (trim_mode && is_ws) begin
      // hold inner whitespace, drop leading whitespace
      if (!leading_ws) begin
        cmd.pre_pct  = (esc_cnt != ESC_NONE);
        cmd.pre_chr  = (esc_cnt == ESC_TWO);
        cmd.pre_char = esc_chr;
        esc_cnt_next = ESC_NONE;
        if (run_cnt < CNT_W'(WS_RUN_MAX)) begin
          run_kinds_next = run_kinds | (WS_RUN_MAX'(is_tab) << run_cnt);
          run_cnt_next   = run_cnt + CNT_W'(1);
        end else begin
          run_cnt_next = CNT_W'(WS_RUN_MAX + 1);
        end
      end
    end else begin
      // replay a held run, which resolves any pending escape first
      if (run_cnt != '0) begin
        cmd.ovf      = run_over;
        cmd.pre_pct  = (esc_cnt != ESC_NONE);
        cmd.pre_chr  = (esc_cnt == ESC_TWO);
        cmd.pre_char = esc_chr;
        cmd_ws_cnt   = run_over ? RUN_W'(WS_RUN_MAX) : run_cnt[RUN_W-1:0];
        cmd_ws_kinds = run_kinds;
        esc_eff      = ESC_NONE;
      end
      run_cnt_next    = '0;
      run_kinds_next  = '0;
      leading_ws_next = 1'b0;
      esc_cnt_next    = ESC_NONE;
      if (phase == PH_KEY) begin
        key_nonempty_next = 1'b1;
      end
      // decode the byte against the escape state
      case (esc_eff)
        ESC_ONE: begin
          if (hv_b[4]) begin
            esc_cnt_next = ESC_TWO;
            esc_chr_next = in_byte;
          end else begin
            cmd.pre_pct = 1'b1;
            plain       = 1'b1;
          end
        end
        ESC_TWO: begin
          if (hv_b[4]) begin
            cmd.data_en   = 1'b1;
            cmd.data_byte = {hv_c[3:0], hv_b[3:0]};
          end else begin
            cmd.pre_pct  = 1'b1;
            cmd.pre_chr  = 1'b1;
            cmd.pre_char = esc_chr;
            plain        = 1'b1;
          end
        end
        default: plain = 1'b1;
      endcase
      if (plain) begin
        if (in_byte == CH_PLUS) begin
          cmd.data_en   = 1'b1;
          cmd.data_byte = CH_SPACE;
        end else if (in_byte == CH_PCT) begin
          esc_cnt_next = ESC_ONE;
        end else begin
          cmd.data_en   = 1'b1;
          cmd.data_byte = in_byte;
        end
      end
    end

    // end of text closes the part after this byte
    if (in_eot && in_byte != part_separator) begin
      cmd.ovf = cmd.ovf | (run_cnt_next > CNT_W'(WS_RUN_MAX));
      if ((phase_next == PH_KEY || phase_next == PH_VALUE) && key_nonempty_next) begin
        cmd.post_pct  = (esc_cnt_next != ESC_NONE);
        cmd.post_chr  = (esc_cnt_next == ESC_TWO);
        cmd.post_char = esc_chr_next;
        cmd.marker    = 1'b1;
      end
      phase_next        = PH_KEY;
      key_nonempty_next = 1'b0;
      leading_ws_next   = 1'b1;
      esc_cnt_next      = ESC_NONE;
      esc_chr_next      = 8'h00;
      run_cnt_next      = '0;
      run_kinds_next    = '0;
    end
  end

  // Push only items that give results
  assign nonempty = cmd.pre_pct || cmd.data_en || cmd.post_pct || cmd.marker ||
                    (cmd_ws_cnt != '0);
  assign push     = accept && nonempty;

  // Decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_KEY;
      key_nonempty <= 1'b0;
      leading_ws   <= 1'b1;
      esc_cnt      <= ESC_NONE;
      esc_chr      <= 8'h00;
      run_cnt      <= '0;
      run_kinds    <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      key_nonempty <= key_nonempty_next;
      leading_ws   <= leading_ws_next;
      esc_cnt      <= esc_cnt_next;
      esc_chr      <= esc_chr_next;
      run_cnt      <= run_cnt_next;
      run_kinds    <= run_kinds_next;
    end
  end

endmodule

>>> rtl/core/kvd_queue.sv
// Short command queue between front and back end.
// Generic data width; uses kvd_pkg for the default depth.
module kvd_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = kvd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] wr_data,
  output logic          full,
  output logic          valid,
  input  logic          pop,
  output logic [DW-1:0] rd_data
);
  import kvd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DW-1:0]    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign rd_data = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

>>> rtl/core/kvd_back.sv
// Back end: plays out one command as a series of result items, one per cycle while
// the output is not stalled by m_ready, into an output register. Uses kvd_pkg.
module kvd_back #(
  parameter int WS_RUN_MAX = kvd_pkg::WS_RUN_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  kvd_pkg::cmd_t                   q_cmd,
  input  logic [$clog2(WS_RUN_MAX+1)-1:0] q_ws_cnt,
  input  logic [WS_RUN_MAX-1:0]           q_ws_kinds,
  output logic                            m_valid,
  input  logic                            m_ready,
  output logic [1:0]                      m_kind,
  output logic [7:0]                      m_byte,
  output logic                            m_last,
  output logic                            m_ovf
);
  import kvd_pkg::*;

  localparam int RUN_W = $clog2(WS_RUN_MAX + 1);

  cmd_t                  w, w_next;
  logic [RUN_W-1:0]      w_cnt, w_cnt_next;
  logic [WS_RUN_MAX-1:0] w_kinds, w_kinds_next;
  logic                  w_valid;

  logic       adv;
  logic       rest_empty;
  logic       load;
  logic [1:0] e_kind;
  logic [7:0] e_byte;

  assign adv = w_valid && (!m_valid || m_ready);

  // Pick the earliest pending result and clear it
  always_comb begin
    w_next       = w;
    w_cnt_next   = w_cnt;
    w_kinds_next = w_kinds;
    e_kind       = w.val_kind ? KIND_VALUE : KIND_KEY;
    e_byte       = 8'h00;
    if (w.pre_pct) begin
      e_byte         = CH_PCT;
      w_next.pre_pct = 1'b0;
    end else if (w.pre_chr) begin
      e_byte         = w.pre_char;
      w_next.pre_chr = 1'b0;
    end else if (w_cnt != '0) begin
      e_byte       = w_kinds[0] ? CH_TAB : CH_SPACE;
      w_kinds_next = w_kinds >> 1;
      w_cnt_next   = w_cnt - RUN_W'(1);
    end else if (w.data_en) begin
      e_byte         = w.data_byte;
      w_next.data_en = 1'b0;
    end else if (w.post_pct) begin
      e_byte          = CH_PCT;
      w_next.post_pct = 1'b0;
    end else if (w.post_chr) begin
      e_byte          = w.post_char;
      w_next.post_chr = 1'b0;
    end else begin
      e_kind        = KIND_END;
      w_next.marker = 1'b0;
    end
  end

  assign rest_empty = !(w_next.pre_pct || w_next.pre_chr || w_next.data_en ||
                        w_next.post_pct || w_next.post_chr || w_next.marker) &&
                      (w_cnt_next == '0);
  assign load  = q_valid && (!w_valid || (adv && rest_empty));
  assign q_pop = load;

  // Working command control
  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else if (load) begin
      w_valid <= 1'b1;
    end else if (adv && rest_empty) begin
      w_valid <= 1'b0;
    end
  end

  // Working command payload
  always_ff @(posedge clk) begin
    if (load) begin
      w       <= q_cmd;
      w_cnt   <= q_ws_cnt;
      w_kinds <= q_ws_kinds;
    end else if (adv) begin
      w       <= w_next;
      w_cnt   <= w_cnt_next;
      w_kinds <= w_kinds_next;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      m_kind <= e_kind;
      m_byte <= e_byte;
      m_last <= rest_empty;
      m_ovf  <= w.ovf;
    end
  end

endmodule

>>> rtl/core/key_value_list_url_decoder.sv
// Path: an item's results pass through the command queue, the back end's working
// command register and the output register. Throughput: one result item per cycle
// from the back end while m_axis_tready holds; the front takes one item per cycle
// while the 2-entry command queue has room. Items that give no result are not queued.
// Reset (rst, synchronous): clears part state, queue and output; configuration
// returns to separator '&' and trim off.
module key_value_list_url_decoder #(
  parameter int WS_RUN_MAX  = kvd_pkg::WS_RUN_MAX_DEF,
  parameter int QUEUE_DEPTH = kvd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [kvd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] text_byte
  input  logic                             s_axis_tlast,  // end_of_text
  // result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [kvd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [7:0] out_byte, [8] ws_overflow
  output logic [kvd_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,  // [1:0] out_kind
  output logic                             m_axis_tlast,  // run_last
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [7:0]                       cfg_data
);
  import kvd_pkg::*;

  localparam int RUN_W = $clog2(WS_RUN_MAX + 1);
  localparam int Q_W   = $bits(cmd_t) + RUN_W + WS_RUN_MAX;

  logic [7:0] part_separator;
  logic       trim_mode;

  logic                  push;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  cmd_t                  f_cmd, b_cmd;
  logic [RUN_W-1:0]      f_ws_cnt, b_ws_cnt;
  logic [WS_RUN_MAX-1:0] f_ws_kinds, b_ws_kinds;
  logic [Q_W-1:0]        q_rd_data;
  logic [7:0]            out_byte;
  logic                  out_ovf;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      part_separator <= PART_SEPARATOR_RST;
      trim_mode      <= TRIM_MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PART_SEPARATOR: part_separator <= cfg_data;
        CFG_TRIM_MODE:      trim_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  kvd_front #(
    .WS_RUN_MAX(WS_RUN_MAX)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_byte        (s_axis_tdata[7:0]),
    .in_eot         (s_axis_tlast),
    .part_separator (part_separator),
    .trim_mode      (trim_mode),
    .q_full         (q_full),
    .push           (push),
    .cmd            (f_cmd),
    .cmd_ws_cnt     (f_ws_cnt),
    .cmd_ws_kinds   (f_ws_kinds)
  );

  kvd_queue #(
    .DW    (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data ({f_cmd, f_ws_cnt, f_ws_kinds}),
    .full    (q_full),
    .valid   (q_valid),
    .pop     (q_pop),
    .rd_data (q_rd_data)
  );

  assign {b_cmd, b_ws_cnt, b_ws_kinds} = q_rd_data;

  kvd_back #(
    .WS_RUN_MAX(WS_RUN_MAX)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_cmd      (b_cmd),
    .q_ws_cnt   (b_ws_cnt),
    .q_ws_kinds (b_ws_kinds),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .m_kind     (m_axis_tuser),
    .m_byte     (out_byte),
    .m_last     (m_axis_tlast),
    .m_ovf      (out_ovf)
  );

  // Pack result fields
  assign m_axis_tdata = {(OUT_TDATA_W - 9)'(0), out_ovf, out_byte};

endmodule

>>> rtl/core/kvd_checker.sv
// Port-level checks on the result stream of the key/value list decoder.
// Uses kvd_pkg; bound to key_value_list_url_decoder at the end of this file.
module kvd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [kvd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [kvd_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  input logic                            m_axis_tlast
);
  import kvd_pkg::*;

  // A stalled item holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  // End marker carries a zero byte and closes the item's results
  a_end_fmt: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_END |->
      m_axis_tdata[7:0] == 8'h00 && m_axis_tlast)
    else $error("end marker with data or not last");

  // Kind stays within key, value and end
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      m_axis_tuser == KIND_KEY || m_axis_tuser == KIND_VALUE || m_axis_tuser == KIND_END)
    else $error("unknown result kind");

  // Overflow flag is the same on all results of one item
  a_ovf_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
      m_axis_tdata[8] == $past(m_axis_tdata[8]))
    else $error("overflow flag changed within one item's results");

endmodule

bind key_value_list_url_decoder kvd_checker u_kvd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/kvd_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the key/value list decoder: watches config, input and result streams,
// decodes each accepted text byte with its own model and compares results in order.
// Depends on kvd_pkg for the register indexes, result kinds and character codes.
module kvd_scoreboard #(
  parameter int WS_RUN_MAX = kvd_pkg::WS_RUN_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          results_owed
);
  import kvd_pkg::*;

  localparam logic [7:0] CH_DIG0 = 8'h30;
  localparam logic [7:0] CH_DIG9 = 8'h39;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_F = 8'h66;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_F = 8'h46;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       run_last;
    logic       ws_ovf;
  } decoded_t;

  decoded_t decoded_q[$];

  // Mirrored configuration
  logic [7:0] sep_reg;
  logic       trim_reg;

  // Part state
  phase_t      phase;
  logic        key_seen;
  logic        at_lead;
  logic [1:0]  esc_state;
  logic [7:0]  esc_first;
  int          ws_count;
  logic [63:0] ws_tabs;

  // Results of the item being decoded
  logic [1:0] step_kind[$];
  logic [7:0] step_byte[$];
  logic       step_ovf;

  initial fail_count = 0;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] kvd mismatch: %s", $time, msg);
  endtask

  // Bit 4 flags a hex digit, bits 3:0 carry its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= CH_DIG0 && c <= CH_DIG9) return {1'b1, c[3:0]};
    if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F))
      return {1'b1, 4'(c[3:0] + 4'd9)};
    return 5'd0;
  endfunction

  function automatic logic [1:0] cur_kind();
    return (phase == PH_VALUE) ? KIND_VALUE : KIND_KEY;
  endfunction

  task automatic emit(input logic [1:0] k, input logic [7:0] b);
    step_kind.insert(step_kind.size(), k);
    step_byte.insert(step_byte.size(), b);
  endtask

  task automatic put_plain(input logic [7:0] b);
    if (b == CH_PLUS) emit(cur_kind(), CH_SPACE);
    else if (b == CH_PCT) esc_state = ESC_ONE;
    else emit(cur_kind(), b);
  endtask

  // Run one byte through the escape decoder
  task automatic unescape_byte(input logic [7:0] b);
    logic [4:0] lo;
    logic [4:0] hi;
    lo = hex_digit(b);
    if (phase == PH_KEY) key_seen = 1'b1;
    case (esc_state)
      ESC_ONE: begin
        if (lo[4]) begin
          esc_first = b;
          esc_state = ESC_TWO;
        end else begin
          emit(cur_kind(), CH_PCT);
          esc_state = ESC_NONE;
          put_plain(b);
        end
      end
      ESC_TWO: begin
        if (lo[4]) begin
          hi = hex_digit(esc_first);
          emit(cur_kind(), {hi[3:0], lo[3:0]});
          esc_state = ESC_NONE;
        end else begin
          emit(cur_kind(), CH_PCT);
          emit(cur_kind(), esc_first);
          esc_state = ESC_NONE;
          put_plain(b);
        end
      end
      default: begin
        esc_state = ESC_NONE;
        put_plain(b);
      end
    endcase
  endtask

  // Emit a pending escape as literal text
  task automatic flush_escape();
    if (esc_state == ESC_ONE) begin
      emit(cur_kind(), CH_PCT);
    end else if (esc_state == ESC_TWO) begin
      emit(cur_kind(), CH_PCT);
      emit(cur_kind(), esc_first);
    end
    esc_state = ESC_NONE;
  endtask

  task automatic drop_run();
    if (ws_count > WS_RUN_MAX) step_ovf = 1'b1;
    ws_count = 0;
    ws_tabs  = '0;
  endtask

  // Replay held whitespace, clipped to the run depth
  task automatic replay_run();
    int          cnt;
    logic [63:0] tabs;
    cnt  = (ws_count > WS_RUN_MAX) ? WS_RUN_MAX : ws_count;
    tabs = ws_tabs;
    if (ws_count > WS_RUN_MAX) step_ovf = 1'b1;
    ws_count = 0;
    ws_tabs  = '0;
    for (int i = 0; i < cnt; i++) unescape_byte(tabs[i] ? CH_TAB : CH_SPACE);
  endtask

  task automatic hold_ws(input logic [7:0] b);
    if (ws_count < WS_RUN_MAX) begin
      if (b == CH_TAB) ws_tabs[ws_count] = 1'b1;
      ws_count++;
    end else begin
      ws_count = WS_RUN_MAX + 1;
    end
  endtask

  task automatic end_part();
    drop_run();
    if (phase != PH_SKIP && key_seen) begin
      flush_escape();
      emit(KIND_END, 8'h00);
    end
    phase     = PH_KEY;
    key_seen  = 1'b0;
    at_lead   = 1'b1;
    esc_state = ESC_NONE;
    esc_first = 8'h00;
  endtask

  // Decode one text byte and queue the results it causes
  task automatic decode_item(input logic [7:0] b, input logic eot);
    int       n;
    decoded_t item;
    step_kind.delete();
    step_byte.delete();
    step_ovf = 1'b0;
    if (b == sep_reg) begin
      end_part();
    end else if (phase == PH_SKIP) begin
      // rest of a part with an empty key: drop
    end else if (phase == PH_KEY && b == CH_EQUAL) begin
      drop_run();
      if (key_seen) begin
        flush_escape();
        phase   = PH_VALUE;
        at_lead = 1'b1;
      end else begin
        phase = PH_SKIP;
      end
    end else if (trim_reg && (b == CH_SPACE || b == CH_TAB)) begin
      if (!at_lead) begin
        flush_escape();
        hold_ws(b);
      end
    end else begin
      replay_run();
      unescape_byte(b);
      at_lead = 1'b0;
    end
    if (eot && b != sep_reg) end_part();
    n = step_kind.size();
    for (int k = 0; k < n; k++) begin
      item = '{step_kind[k], step_byte[k], k == n - 1, step_ovf};
      decoded_q.insert(decoded_q.size(), item);
    end
  endtask

  task automatic reset_model();
    sep_reg   = PART_SEPARATOR_RST;
    trim_reg  = TRIM_MODE_RST;
    phase     = PH_KEY;
    key_seen  = 1'b0;
    at_lead   = 1'b1;
    esc_state = ESC_NONE;
    esc_first = 8'h00;
    ws_count  = 0;
    ws_tabs   = '0;
    decoded_q.delete();
  endtask

  task automatic check_result();
    decoded_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: kind %0d byte %02h",
                                m_axis_tuser, m_axis_tdata[7:0]));
    end else begin
      want = decoded_q.pop_front();
      if (m_axis_tuser !== want.kind)
        report_mismatch($sformatf("out_kind %0d, expected %0d", m_axis_tuser, want.kind));
      if (m_axis_tdata[7:0] !== want.out_byte)
        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                  m_axis_tdata[7:0], want.out_byte));
      if (m_axis_tlast !== want.run_last)
        report_mismatch($sformatf("run_last %0b, expected %0b", m_axis_tlast, want.run_last));
      if (m_axis_tdata[8] !== want.ws_ovf)
        report_mismatch($sformatf("ws_overflow %0b, expected %0b",
                                  m_axis_tdata[8], want.ws_ovf));
    end
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      reset_model();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PART_SEPARATOR) sep_reg = cfg_data;
        else trim_reg = cfg_data[0];
      end
      if (s_axis_tvalid && s_axis_tready) decode_item(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
    results_owed <= decoded_q.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Top of the key/value list decoder bench: clock, reset, text stimulus, config phases
// and back-pressure. Depends on kvd_pkg, key_value_list_url_decoder and kvd_scoreboard.
module tb;
  import kvd_pkg::*;

  localparam int         WS_RUN_MAX = WS_RUN_MAX_DEF;
  localparam logic [7:0] CH_SEMI    = 8'h3B;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] text_byte
  logic        s_axis_tlast  = 1'b0;   // end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] out_byte, [8] ws_overflow
  logic [1:0]  m_axis_tuser;           // [1:0] out_kind
  logic        m_axis_tlast;           // run_last
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic        cfg_index     = CFG_PART_SEPARATOR;
  logic [7:0]  cfg_data      = 8'h00;

  int fail_count;
  int results_owed;

  int   items_sent = 0;
  bit   tx_free    = 1'b0;
  bit   rx_free    = 1'b0;
  bit   hold_req   = 1'b0;
  logic [7:0] text_q[$];

  string alnum_set  = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  string hex_set    = "0123456789abcdefABCDEF";
  string nonhex_set = "ghijkxyzGXZ";

  key_value_list_url_decoder #(.WS_RUN_MAX(WS_RUN_MAX)) uut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  kvd_scoreboard #(.WS_RUN_MAX(WS_RUN_MAX)) watch (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .results_owed
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Result side: random stalls, free-running stretches and one long hold-off
  initial begin : receiver
    int stall;
    int r;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_free) begin
        m_axis_tready <= 1'b1;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_axis_tready <= 1'b1;
        end else if (r < 92) begin
          m_axis_tready <= 1'b0;
          stall = $urandom_range(0, 2);
        end else begin
          m_axis_tready <= 1'b0;
          stall = $urandom_range(5, 25);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Append one byte to the pending text
  task automatic append_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  // Offer one text byte and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_text(input bit eot);
    logic [7:0] b;
    while (text_q.size() != 0) begin
      b = text_q.pop_front();
      send_byte(b, eot && text_q.size() == 0);
    end
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  // Stop offering and wait until every result has come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] sep, input logic trim);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PART_SEPARATOR;
    cfg_data  <= sep;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_TRIM_MODE;
    cfg_data  <= {7'd0, trim};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_ws(input int n);
    repeat (n) append_byte($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
  endtask

  function automatic logic [7:0] pick_hex();
    return hex_set[$urandom_range(0, hex_set.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_alnum();
    return alnum_set[$urandom_range(0, alnum_set.len() - 1)];
  endfunction

  // One token of key or value text
  task automatic add_token();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      append_byte(pick_alnum());
    end else if (r < 55) begin
      append_byte(CH_PLUS);
    end else if (r < 70) begin
      append_byte(CH_PCT);
      append_byte(pick_hex());
      append_byte(pick_hex());
    end else if (r < 76) begin
      // broken or cut-off escape
      n = $urandom_range(0, 2);
      append_byte(CH_PCT);
      if (n >= 1) append_byte(pick_hex());
      if (n == 2) append_byte(nonhex_set[$urandom_range(0, nonhex_set.len() - 1)]);
    end else if (r < 90) begin
      add_ws($urandom_range(1, 3));
    end else if (r < 92) begin
      add_ws($urandom_range(30, 40));
    end else begin
      append_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Build and send one part, ending it with the separator and/or end of text
  task automatic add_part(input logic [7:0] sep, input bit finish);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) add_ws($urandom_range(1, 2));
      repeat ($urandom_range(0, 4)) add_token();
      if ($urandom_range(0, 19) != 0) begin
        append_byte(CH_EQUAL);
        if ($urandom_range(0, 3) == 0) add_ws($urandom_range(1, 2));
        repeat ($urandom_range(0, 4)) add_token();
      end
    end
    if (!finish || $urandom_range(0, 1)) append_byte(sep);
    if (text_q.size() == 0) append_byte(pick_alnum());
    send_text(finish);
  endtask

  function automatic logic [7:0] pick_special_sep();
    case ($urandom_range(0, 5))
      0:       return CH_EQUAL;
      1:       return CH_PCT;
      2:       return CH_PLUS;
      3:       return CH_SPACE;
      4:       return CH_TAB;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    logic [7:0] sep;
    logic       trim;
    int         stop_at;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: escapes, plus, empty key, broken escapes at end of text, byte extremes
    push_str("a=%4a+&");
    send_text(1'b0);
    push_str("=x&");
    send_text(1'b0);
    push_str("%G%4");
    send_text(1'b1);
    append_byte(8'h00);
    append_byte(CH_EQUAL);
    append_byte(8'hFF);
    send_text(1'b1);

    // Directed trim: leading drop, escape cut by whitespace, inner replay, trailing drop
    wait_idle();
    set_config(CH_SEMI, 1'b1);
    push_str(" k%4 x =\tv;");
    send_text(1'b0);

    // Random phases over separator and trim settings
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      case (p)
        0:       begin sep = CH_SEMI;            trim = 1'b1;                     end
        1:       begin sep = PART_SEPARATOR_RST; trim = 1'b0;                     end
        2:       begin sep = 8'h00;              trim = 1'b1;                     end
        3:       begin sep = 8'hFF;              trim = 1'b0;                     end
        4:       begin sep = pick_special_sep(); trim = 1'b1;                     end
        5:       begin sep = pick_special_sep(); trim = 1'($urandom_range(0, 1)); end
        default: begin sep = PART_SEPARATOR_RST; trim = 1'b1;                     end
      endcase
      set_config(sep, trim);
      tx_free = (p == 6) || ($urandom_range(0, 3) == 0);
      rx_free = (p == 6) || (p != 1 && $urandom_range(0, 4) == 0);
      // fill the block while the result side holds off
      if (p == 1) begin
        tx_free  = 1'b1;
        hold_req = 1'b1;
      end
      stop_at = items_sent + 24;
      while (items_sent < stop_at) begin
        add_part(sep, $urandom_range(0, 4) == 0);
        if ($urandom_range(0, 19) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
